@@ design/qws_pkg.sv @@
// shared types and constants for the fifo queue with search
package qws_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int FOUND_W     = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH   = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_POP    = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_SEARCH = REQ_W'(2);

  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = STATUS_W'(3);

  typedef logic signed [DATA_W-1:0] data_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic  pop;
    logic  search;
    data_t data;
  } cell_ctl_t;

endpackage

@@ design/qws_cell.sv @@
// one queue cell: holds an entry, shifts toward the head on pop, compares on search
module qws_cell (
  input  logic              clk,
  input  qws_pkg::cell_ctl_t ctl,
  input  logic              wr_en,
  input  logic              occupied,
  input  qws_pkg::data_t    right_value,
  output qws_pkg::data_t    value,
  output logic              match
);
  import qws_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      value <= right_value;
    end else if (wr_en) begin
      value <= ctl.data;
    end
    if (ctl.search) begin
      match <= occupied && (value == ctl.data);
    end
  end

endmodule

@@ design/fifo_queue_with_search_core.sv @@
// top level of the fifo queue with search: cell chain, request control, result register
//
// A bounded FIFO of signed 32-bit values built as a chain of QUEUE_DEPTH cells,
// with cell 0 always holding the oldest entry. Each request beat gives exactly
// one response beat. A push writes the cell just past the last occupied one and
// a pop shifts the whole chain one cell toward the head, so both finish in the
// accept cycle: one request per cycle unless stalled. In a search, every cell
// compares its entry with the search value and registers a match bit, then a
// two-level priority encoder over the match bits picks the first hit from the
// head. The request side stalls while a search is resolving, and also while a
// finished response sits in the output register under stall. Push onto a full
// queue answers status full, pop from an empty queue answers status empty with
// a zero value, a search without a hit answers not-found with position zero,
// and the unused request code is answered ok with everything zero. The store
// needs no clearing after reset; only occupied cells are ever read.
module fifo_queue_with_search_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [qws_pkg::REQ_W-1:0]     req_type,
  input  qws_pkg::data_t                data_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [qws_pkg::STATUS_W-1:0]  status,
  output qws_pkg::data_t                popped_value,
  output logic [qws_pkg::FOUND_W-1:0]   found_position
);
  import qws_pkg::*;

  localparam int GRP_N = (QUEUE_DEPTH + 3) / 4;

  // entry count and search-in-flight flag
  logic [CNT_W-1:0] cnt;
  logic             pend;

  logic accept;
  logic do_push;
  logic do_pop;
  logic do_search;
  logic rsp_free;
  logic load_req;
  logic load_search;

  cell_ctl_t              ctl;
  data_t                  cell_value [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] wr_en;
  logic [QUEUE_DEPTH-1:0] occupied;

  logic [GRP_N*4-1:0] match_pad;
  logic [GRP_N-1:0]   grp_hit;
  logic [1:0]         grp_off [GRP_N];
  logic [POS_W-1:0]   pos;

  logic [STATUS_W-1:0] res_status;
  data_t               res_popped;

  // output register is free when empty or being drained this cycle
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = pend || !rsp_free;
  assign accept    = req_valid && !req_stall;

  assign do_push   = accept && (req_type == REQ_PUSH) && (cnt != CNT_W'(QUEUE_DEPTH));
  assign do_pop    = accept && (req_type == REQ_POP) && (cnt != '0);
  assign do_search = accept && (req_type == REQ_SEARCH);

  // searches answer from the registered match bits once the output register is free, everything else answers at once
  assign load_req    = accept && (req_type != REQ_SEARCH);
  assign load_search = pend && rsp_free;

  assign ctl.pop    = do_pop;
  assign ctl.search = do_search;
  assign ctl.data   = data_value;

  // the cell chain, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    data_t right_value;

    assign occupied[i] = (CNT_W'(i) < cnt);
    assign wr_en[i]    = do_push && (cnt == CNT_W'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    qws_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .wr_en       (wr_en[i]),
      .occupied    (occupied[i]),
      .right_value (right_value),
      .value       (cell_value[i]),
      .match       (match[i])
    );
  end

  // first hit from the head: lowest hit inside each group of four, then lowest group
  assign match_pad = (GRP_N*4)'(match);

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_hit[g] = |match_pad[g*4 +: 4];
      grp_off[g] = 2'd0;
      for (int j = 3; j >= 0; j--) begin
        if (match_pad[g*4 + j]) begin
          grp_off[g] = 2'(j);
        end
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        pos = POS_W'(g*4 + int'(grp_off[g]) + 1);
      end
    end
  end

  // result of a push, pop or unused code
  always_comb begin
    res_status = ST_OK;
    res_popped = '0;
    case (req_type)
      REQ_PUSH: begin
        if (cnt == CNT_W'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end
      end
      REQ_POP: begin
        if (cnt == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_popped = cell_value[0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (do_push) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop) begin
        cnt <= cnt - CNT_W'(1);
      end

      if (do_search) begin
        pend <= 1'b1;
      end else if (load_search) begin
        pend <= 1'b0;
      end

      if (load_req || load_search) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (load_search) begin
      status         <= (pos == '0) ? ST_NOTFOUND : ST_OK;
      popped_value   <= '0;
      found_position <= FOUND_W'(pos);
    end else if (load_req) begin
      status         <= res_status;
      popped_value   <= res_popped;
      found_position <= '0;
    end
  end

  // count never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // a pending search resolves as soon as the output register is free
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    pend && rsp_free |=> !pend && rsp_valid)
    else $error("search result not delivered");

  // an accepted pop on a non-empty queue takes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_POP) && (cnt != '0) |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("pop did not decrement entry count");

  // a response only appears after an accepted request or a resolved search
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(load_req || load_search))
    else $error("response beat without a request");

endmodule

@@ bench/qws_checker.sv @@
// response checker for the fifo queue with search: mirrors the queue and checks each response beat
module qws_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  logic [qws_pkg::REQ_W-1:0]    req_type,
  input  qws_pkg::data_t               data_value,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  logic [qws_pkg::STATUS_W-1:0] status,
  input  qws_pkg::data_t               popped_value,
  input  logic [qws_pkg::FOUND_W-1:0]  found_position,
  output int                           error_count,
  output int                           pending_count,
  output int                           checked_count
);
  import qws_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    data_t               popped;
    logic [FOUND_W-1:0]  position;
  } answer_t;

  // mirror of the queue contents
  data_t   slots [QUEUE_DEPTH];
  int      head;
  int      fill;
  answer_t answers_due [$];
  answer_t want;

  initial begin
    error_count   = 0;
    pending_count = 0;
    checked_count = 0;
    head          = 0;
    fill          = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // applies one request to the mirror and returns the answer it should give
  function automatic answer_t apply_request(input logic [REQ_W-1:0] kind, input data_t value);
    answer_t a;
    bit      hit;
    a   = '0;
    hit = 1'b0;
    case (kind)
      REQ_PUSH: begin
        if (fill >= QUEUE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          slots[(head + fill) % QUEUE_DEPTH] = value;
          fill++;
        end
      end
      REQ_POP: begin
        if (fill == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.popped = slots[head];
          head     = (head + 1) % QUEUE_DEPTH;
          fill--;
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < fill; i++) begin
          if (!hit && slots[(head + i) % QUEUE_DEPTH] == value) begin
            hit        = 1'b1;
            a.position = FOUND_W'(i + 1);
          end
        end
        if (!hit) a.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      fill = 0;
      answers_due.delete();
    end else begin
      if (req_valid && !req_stall) answers_due.push_back(apply_request(req_type, data_value));
      if (rsp_valid && !rsp_stall) begin
        checked_count++;
        if (answers_due.size() == 0) begin
          report("response beat with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status)
            report($sformatf("beat %0d status %0d, expected %0d",
                             checked_count, status, want.status));
          if (popped_value !== want.popped)
            report($sformatf("beat %0d popped_value %0h, expected %0h",
                             checked_count, popped_value, want.popped));
          if (found_position !== want.position)
            report($sformatf("beat %0d found_position %0d, expected %0d",
                             checked_count, found_position, want.position));
        end
      end
    end
    pending_count = answers_due.size();
  end

endmodule

@@ bench/fifo_queue_with_search_core_tb.sv @@
// testbench top for the fifo queue with search: clock, reset, request and response traffic
module fifo_queue_with_search_core_tb;
  import qws_pkg::*;

  // request code the block must answer ok with all fields zero
  localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);
  localparam int RANDOM_ITEMS = 1625;
  // length of the long response hold-off that backs up the request side
  localparam int HOLD_CYCLES  = 80;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [REQ_W-1:0]    req_type;
  data_t               data_value;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [STATUS_W-1:0] status;
  data_t               popped_value;
  logic [FOUND_W-1:0]  found_position;

  int error_count;
  int pending_count;
  int checked_count;

  // sender bookkeeping
  int    burst_left;
  int    sent_push;
  int    sent_pop;
  int    sent_search;
  int    sent_other;
  // small set of values reused so that searches hit and duplicates occur
  data_t value_pool [8];

  fifo_queue_with_search_core uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .data_value     (data_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .popped_value   (popped_value),
    .found_position (found_position)
  );

  qws_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .data_value     (data_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .popped_value   (popped_value),
    .found_position (found_position),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // offers one request beat and holds it until accepted; called and returns at a falling edge
  task automatic send_req(input logic [REQ_W-1:0] kind, input data_t value);
    int gap;
    if (burst_left == 0) begin
      // end of burst: idle for a random gap, sometimes none at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_valid  = 1'b1;
    req_type   = kind;
    data_value = value;
    // payload stays put while the block stalls
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    burst_left--;
    case (kind)
      REQ_PUSH:   sent_push++;
      REQ_POP:    sent_pop++;
      REQ_SEARCH: sent_search++;
      default:    sent_other++;
    endcase
  endtask

  // mostly pool values, then full-width random, then a cluster around zero
  function automatic data_t pick_value();
    case ($urandom_range(0, 3))
      0, 1:    pick_value = value_pool[$urandom_range(0, 7)];
      2:       pick_value = data_t'($urandom);
      default: pick_value = data_t'($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  // receiver: switches between stall patterns, with two long hold-offs
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    rsp_stall = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      // long hold-off while the sender keeps offering, so the request side backs up
      if (cyc == 300 || cyc == 2500) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0:       rsp_stall = 1'b0;
          1:       rsp_stall = ($urandom_range(0, 3) == 0);
          2:       rsp_stall = ($urandom_range(0, 3) != 0);
          default: rsp_stall = (cyc % 3 == 0);
        endcase
      end
    end
  end

  // sender and verdict
  initial begin
    int                 mix;
    int                 roll;
    logic [REQ_W-1:0]   kind;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_type    = REQ_PUSH;
    data_value  = '0;
    burst_left  = 0;
    sent_push   = 0;
    sent_pop    = 0;
    sent_search = 0;
    sent_other  = 0;
    mix         = 0;
    value_pool[0] = data_t'(32'h8000_0000);
    value_pool[1] = data_t'(32'h7fff_ffff);
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int k = 4; k < 8; k++) value_pool[k] = data_t'($urandom);

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: empty-queue cases first
    send_req(REQ_POP, data_t'(32'h1234_5678));
    send_req(REQ_SEARCH, '0);
    // extremes of the value field
    send_req(REQ_PUSH, data_t'(32'h8000_0000));
    send_req(REQ_PUSH, data_t'(32'h7fff_ffff));
    send_req(REQ_PUSH, '0);
    send_req(REQ_PUSH, -1);
    send_req(REQ_SEARCH, data_t'(32'h8000_0000));
    send_req(REQ_POP, '0);
    // unused code carries data but must change nothing
    send_req(REQ_UNUSED, data_t'(32'hdead_beef));
    // fill to the brim, with duplicates of 0 and -1 further back
    for (int k = 0; k < 13; k++) send_req(REQ_PUSH, data_t'(k - 6));
    // push onto a full queue is refused
    send_req(REQ_PUSH, data_t'(32'h5555_aaaa));
    // first match wins over a later duplicate
    send_req(REQ_SEARCH, -1);
    // match in the last cell
    send_req(REQ_SEARCH, data_t'(6));
    // popped value is gone, so no match
    send_req(REQ_SEARCH, data_t'(32'h8000_0000));

    // random traffic in stretches that lean toward filling, draining or neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) mix = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        kind = REQ_UNUSED;
      end else begin
        case (mix)
          0:       kind = (roll < 70) ? REQ_PUSH : (roll < 85) ? REQ_POP : REQ_SEARCH;
          1:       kind = (roll < 18) ? REQ_PUSH : (roll < 70) ? REQ_POP : REQ_SEARCH;
          default: kind = (roll < 40) ? REQ_PUSH : (roll < 70) ? REQ_POP : REQ_SEARCH;
        endcase
      end
      // refresh the pool now and then so new values enter the queue
      if ($urandom_range(0, 31) == 0) value_pool[$urandom_range(0, 7)] = data_t'($urandom);
      send_req(kind, pick_value());
    end
    req_valid = 1'b0;

    // drain: every outstanding response must come back, then a few quiet cycles
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("requests sent: %0d push, %0d pop, %0d search, %0d unused code",
             sent_push, sent_pop, sent_search, sent_other);
    $display("response beats compared against the queue mirror: %0d", checked_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ fifo_queue_with_search_core.f @@
design/qws_pkg.sv
design/qws_cell.sv
design/fifo_queue_with_search_core.sv
bench/qws_checker.sv
bench/fifo_queue_with_search_core_tb.sv
